// ----- rtl/assert_macros.svh -----
// Assertion macros for the frame dirty-row detector RTL, used by fdrd_track.
// Users need signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define FDRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition never occurs outside reset.
`define FDRD_NEVER(lbl, cond, msg) \
  `FDRD_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/fdrd_pkg.sv -----
// Package for the frame dirty-row detector: sizes, field widths and the
// per-item record passed from the raster scanner to the compare stage.
package fdrd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 2048;

  // payload field widths (fixed by the item format)
  localparam int PIX_W  = 32;
  localparam int FW_W   = 13;
  localparam int FH_W   = 12;
  localparam int TOP_W  = 11;
  localparam int ROWS_W = 12;
  localparam int RW_W   = 13;

  // internal widths derived from the frame size limits
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int SW_W   = $clog2(MAX_WIDTH + 1);
  localparam int SH_W   = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  row;
    logic [SW_W-1:0]   width;
    logic              comparable;
    logic              is_mid;
    logic              row_end;
    logic              frame_end;
  } fdrd_item_t;

endpackage

// ----- rtl/fdrd_if.sv -----
// Valid/ready channel interfaces for pixel items and frame result items.
// Depends on fdrd_pkg for the field widths.
interface fdrd_in_if import fdrd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;

  modport source (output valid, output pixel, output frame_width, output frame_height,
                  input ready);
  modport sink   (input valid, input pixel, input frame_width, input frame_height,
                  output ready);
endinterface

interface fdrd_out_if import fdrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              has_rect;
  logic [TOP_W-1:0]  rect_top;
  logic [ROWS_W-1:0] rect_rows;
  logic [RW_W-1:0]   rect_width;

  modport source (output valid, output has_rect, output rect_top, output rect_rows,
                  output rect_width, input ready);
  modport sink   (input valid, input has_rect, input rect_top, input rect_rows,
                  input rect_width, output ready);
endinterface

// ----- rtl/frame_dirty_row_detector.sv -----
// Frame dirty-row detector. Takes one 32-bit pixel per clock in raster order, compares it
// with the pixel at the same place of the previous frame (held in an on-chip store of
// MAX_WIDTH x MAX_HEIGHT words) and writes the new pixel back. A compare counts only if the
// previous frame had the same clamped width and height. At the last pixel of each frame one
// result item is registered from the compare stage; it reports a full-width rectangle
// from the first to the last differing row when some row's middle pixel changed, otherwise
// all fields are zero. Sustained rate is one pixel per clock: the store is read when a
// pixel is taken and written back from the compare stage. Input stalls only while a frame
// result waits in the output register and the next frame's last pixel is ready to finish.
// The store has no clearing pass; its contents before the first full frame are undefined.
module frame_dirty_row_detector import fdrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fdrd_in_if.sink    in_ch,
  fdrd_out_if.source out_ch
);

  fdrd_item_t        item;
  logic              accept;
  logic              s1_ready;
  logic [PIX_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;

  assign in_ch.ready = s1_ready;
  assign accept      = in_ch.valid && s1_ready;

  fdrd_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel        (in_ch.pixel),
    .frame_width  (in_ch.frame_width),
    .frame_height (in_ch.frame_height),
    .item         (item)
  );

  fdrd_frame_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (item.addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fdrd_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .rd_data  (rd_data),
    .s1_ready (s1_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/fdrd_scan.sv -----
// Raster scanner: clamps the frame size, tracks column/row position, stored
// frame size, and builds the per-item record. Depends on fdrd_pkg.
module fdrd_scan import fdrd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  input  logic [FW_W-1:0]  frame_width,
  input  logic [FH_W-1:0]  frame_height,
  output fdrd_item_t       item
);

  logic [COL_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [SW_W-1:0]  stored_width_r;
  logic [SH_W-1:0]  stored_height_r;
  logic             stored_valid_r;
  logic [SW_W-1:0]  w;
  logic [SH_W-1:0]  h;

  always_comb begin
    priority if (frame_width < FW_W'(2)) begin
      w = SW_W'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w = SW_W'(MAX_WIDTH);
    end else begin
      w = SW_W'(frame_width);
    end
    priority if (frame_height < FH_W'(2)) begin
      h = SH_W'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h = SH_W'(MAX_HEIGHT);
    end else begin
      h = SH_W'(frame_height);
    end
  end

  always_comb begin
    item.pixel      = pixel;
    item.addr       = {row_count_r, column_count_r};
    item.row        = row_count_r;
    item.width      = w;
    item.comparable = stored_valid_r && (stored_width_r == w) && (stored_height_r == h);
    item.is_mid     = (column_count_r == COL_W'(w >> 1));
    // width given with each pixel decides where the row ends
    item.row_end    = (32'(column_count_r) + 1) >= 32'(w);
    item.frame_end  = item.row_end && ((32'(row_count_r) + 1) >= 32'(h));

    column_count_nxt = item.row_end ? '0 : column_count_r + COL_W'(1);
    row_count_nxt    = row_count_r;
    if (item.row_end) begin
      row_count_nxt = item.frame_end ? '0 : row_count_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r  <= '0;
      row_count_r     <= '0;
      stored_width_r  <= '0;
      stored_height_r <= '0;
      stored_valid_r  <= 1'b0;
    end else if (accept) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      if (item.frame_end) begin
        stored_width_r  <= w;
        stored_height_r <= h;
        stored_valid_r  <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fdrd_frame_mem.sv -----
// Previous-frame pixel store: one write port, one registered read port.
// Depends on fdrd_pkg for address and pixel widths.
module fdrd_frame_mem import fdrd_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/fdrd_track.sv -----
// Compare stage: checks each pixel against the stored one, writes the new
// pixel back, tracks differing rows and holds the frame result register.
// Depends on fdrd_pkg, fdrd_if and assert_macros.svh.
`include "assert_macros.svh"

module fdrd_track import fdrd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  fdrd_item_t        item,
  input  logic [PIX_W-1:0]  rd_data,
  output logic              s1_ready,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [PIX_W-1:0]  wr_data,
  fdrd_out_if.source        out_ch
);

  logic             s1_valid_r;
  fdrd_item_t       s1_r;
  logic             row_differs_r, middle_differs_r, first_found_r;
  logic [ROW_W-1:0] first_row_r, last_row_r;

  logic              out_valid_r;
  logic              has_rect_r;
  logic [TOP_W-1:0]  rect_top_r;
  logic [ROWS_W-1:0] rect_rows_r;
  logic [RW_W-1:0]   rect_width_r;

  logic             s1_adv, s1_fire, res_load;
  logic             differs, rd_now, mid_now, ff_now, mark_row;
  logic [ROW_W-1:0] first_now, last_now;
  logic             has_nxt;

  // only a frame-end item waits, and only while the last result is untaken
  assign s1_adv   = !(s1_r.frame_end && out_valid_r && !out_ch.ready);
  assign s1_fire  = s1_valid_r && s1_adv;
  assign s1_ready = !s1_valid_r || s1_adv;
  assign res_load = s1_fire && s1_r.frame_end;

  always_comb begin
    differs   = s1_r.comparable && (rd_data != s1_r.pixel);
    rd_now    = row_differs_r || differs;
    mid_now   = middle_differs_r || (differs && s1_r.is_mid);
    mark_row  = s1_r.row_end && rd_now;
    ff_now    = first_found_r || mark_row;
    first_now = (mark_row && !first_found_r) ? s1_r.row : first_row_r;
    last_now  = mark_row ? s1_r.row : last_row_r;
    has_nxt   = s1_r.comparable && mid_now && ff_now;
  end

  assign wr_en   = s1_fire;
  assign wr_addr = s1_r.addr;
  assign wr_data = s1_r.pixel;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
    if (res_load) begin
      has_rect_r   <= has_nxt;
      rect_top_r   <= has_nxt ? TOP_W'(first_now) : '0;
      rect_rows_r  <= has_nxt ?
                      ROWS_W'({1'b0, last_now} - {1'b0, first_now} + (ROW_W + 1)'(1)) : '0;
      rect_width_r <= has_nxt ? RW_W'(s1_r.width) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      row_differs_r    <= 1'b0;
      middle_differs_r <= 1'b0;
      first_found_r    <= 1'b0;
      first_row_r      <= '0;
      last_row_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        row_differs_r <= s1_r.row_end ? 1'b0 : rd_now;
        if (s1_r.frame_end) begin
          middle_differs_r <= 1'b0;
          first_found_r    <= 1'b0;
          first_row_r      <= '0;
          last_row_r       <= '0;
        end else begin
          middle_differs_r <= mid_now;
          first_found_r    <= ff_now;
          first_row_r      <= first_now;
          last_row_r       <= last_now;
        end
      end

      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.has_rect   = has_rect_r;
  assign out_ch.rect_top   = rect_top_r;
  assign out_ch.rect_rows  = rect_rows_r;
  assign out_ch.rect_width = rect_width_r;

  `FDRD_NEVER(a_rmw_same_addr, wr_en && accept && (wr_addr == item.addr), "write-back hits the entry being read")
  `FDRD_ASSERT(a_result_loaded, res_load |=> out_valid_r, "frame result not registered")
  `FDRD_ASSERT(a_stall_only_end, (s1_valid_r && !s1_adv) |-> (s1_r.frame_end && out_valid_r), "compare stage stalled without pending result")
  `FDRD_ASSERT(a_rect_rows, (out_valid_r && has_rect_r) |-> (rect_rows_r != '0), "reported rectangle has no rows")
  `FDRD_ASSERT(a_empty_result, (out_valid_r && !has_rect_r) |-> (rect_top_r == '0 && rect_rows_r == '0 && rect_width_r == '0), "empty result carries nonzero fields")

endmodule

// ----- tb/fdrd_checker.sv -----
// Checker for the frame dirty-row detector: watches the pixel and result channels,
// keeps its own copy of the previous frame and compares every result item field by field.
// Depends on fdrd_pkg and the channel interfaces in fdrd_if.
module fdrd_checker import fdrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fdrd_in_if   in_ch,
  fdrd_out_if  out_ch,
  output int   fail_count,
  output int   rects_pending
);

  typedef struct packed {
    logic              has_rect;
    logic [TOP_W-1:0]  top;
    logic [ROWS_W-1:0] rows;
    logic [RW_W-1:0]   width;
  } frame_rect_t;

  frame_rect_t      frame_rects[$];
  frame_rect_t      rect_due;
  logic [PIX_W-1:0] prev_frame[int];
  logic [FW_W-1:0]  last_w;
  logic [FH_W-1:0]  last_h;
  logic             last_ok;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             row_dirty;
  logic             mid_dirty;
  logic             any_dirty;
  logic [ROW_W-1:0] first_dirty;
  logic [ROW_W-1:0] last_dirty;

  task automatic track_pixel(input logic [PIX_W-1:0] px, input logic [FW_W-1:0] fw,
                             input logic [FH_W-1:0] fh);
    int               w;
    int               h;
    int               addr;
    logic             same_size;
    logic [PIX_W-1:0] old_px;
    frame_rect_t      rect;
    w = (int'(fw) < 2) ? 2 : (int'(fw) > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
    h = (int'(fh) < 2) ? 2 : (int'(fh) > MAX_HEIGHT) ? MAX_HEIGHT : int'(fh);
    same_size = last_ok && int'(last_w) == w && int'(last_h) == h;
    addr = int'(row) * MAX_WIDTH + int'(col);
    old_px = prev_frame.exists(addr) ? prev_frame[addr] : '0;
    if (same_size && old_px != px) begin
      row_dirty = 1'b1;
      if (int'(col) == w / 2) mid_dirty = 1'b1;
    end
    prev_frame[addr] = px;

    if (int'(col) + 1 < w) begin
      col = col + 1'b1;
    end else begin
      if (row_dirty) begin
        if (!any_dirty) begin
          any_dirty   = 1'b1;
          first_dirty = row;
        end
        last_dirty = row;
      end
      row_dirty = 1'b0;
      col       = '0;
      if (int'(row) + 1 < h) begin
        row = row + 1'b1;
      end else begin
        // frame closes: one result item, zeroed unless a middle pixel changed
        rect = '0;
        if (same_size && mid_dirty && any_dirty) begin
          rect.has_rect = 1'b1;
          rect.top      = TOP_W'(first_dirty);
          rect.rows     = ROWS_W'(int'(last_dirty) - int'(first_dirty) + 1);
          rect.width    = RW_W'(w);
        end
        frame_rects.push_back(rect);
        last_w      = FW_W'(w);
        last_h      = FH_W'(h);
        last_ok     = 1'b1;
        row         = '0;
        mid_dirty   = 1'b0;
        any_dirty   = 1'b0;
        first_dirty = '0;
        last_dirty  = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_rects.delete();
      prev_frame.delete();
      last_w      = '0;
      last_h      = '0;
      last_ok     = 1'b0;
      col         = '0;
      row         = '0;
      row_dirty   = 1'b0;
      mid_dirty   = 1'b0;
      any_dirty   = 1'b0;
      first_dirty = '0;
      last_dirty  = '0;
      fail_count  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        track_pixel(in_ch.pixel, in_ch.frame_width, in_ch.frame_height);
      if (out_ch.valid && out_ch.ready) begin
        if (frame_rects.size() == 0) begin
          $error("result item with no frame end pending");
          fail_count++;
        end else begin
          rect_due = frame_rects.pop_front();
          check_field("has_rect", 32'(rect_due.has_rect), 32'(out_ch.has_rect));
          check_field("rect_top", 32'(rect_due.top), 32'(out_ch.rect_top));
          check_field("rect_rows", 32'(rect_due.rows), 32'(out_ch.rect_rows));
          check_field("rect_width", 32'(rect_due.width), 32'(out_ch.rect_width));
        end
      end
    end
    rects_pending <= frame_rects.size();
  end

endmodule

// ----- tb/tb_frame_dirty_row_detector.sv -----
// Top of the frame dirty-row detector testbench: clock, reset, pixel stimulus and
// result-side stalls; the verdict comes from fdrd_checker. Depends on fdrd_pkg and fdrd_if.
module tb_frame_dirty_row_detector;
  import fdrd_pkg::*;

  typedef enum int {CHG_ANY, CHG_MID_ONLY, CHG_SKIP_MID} chg_mode_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   rects_pending;
  bit   quiet;
  int   src_idle_pct;
  int   sink_stall_pct;

  // stimulus-side view of raster position and store contents, used to shape frames
  logic [PIX_W-1:0] shadow[int];
  int               at_col;
  int               at_row;
  int               kept_w;
  int               kept_h;
  bit               kept_ok;
  int               pixels_sent;
  int               frames_closed;

  fdrd_in_if  pix_ch();
  fdrd_out_if res_ch();

  frame_dirty_row_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch)
  );

  fdrd_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (pix_ch),
    .out_ch        (res_ch),
    .fail_count    (fail_count),
    .rects_pending (rects_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int sat_dim(input int v, input int hi);
    return (v < 2) ? 2 : (v > hi) ? hi : v;
  endfunction

  task automatic put_pixel(input logic [PIX_W-1:0] px, input logic [FW_W-1:0] fw,
                           input logic [FH_W-1:0] fh);
    int w;
    int h;
    int c;
    int r;
    w = sat_dim(int'(fw), MAX_WIDTH);
    h = sat_dim(int'(fh), MAX_HEIGHT);
    c = at_col;
    r = at_row;
    // never compare against a store entry that was never written: break the size match
    if (kept_ok && w == kept_w && h == kept_h && !shadow.exists(r * MAX_WIDTH + c)) begin
      fh = (kept_h == 2) ? FH_W'(3) : FH_W'(2);
      h  = int'(fh);
    end
    if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.pixel        <= px;
    pix_ch.frame_width  <= fw;
    pix_ch.frame_height <= fh;
    do @(posedge clk); while (!pix_ch.ready);
    shadow[r * MAX_WIDTH + c] = px;
    pixels_sent++;
    if (c + 1 < w) begin
      at_col = c + 1;
    end else begin
      at_col = 0;
      if (r + 1 < h) begin
        at_row = r + 1;
      end else begin
        at_row  = 0;
        kept_w  = w;
        kept_h  = h;
        kept_ok = 1'b1;
        frames_closed++;
      end
    end
  endtask

  // Whole frame of w x h. Pixels in rows lo..hi change with probability pct, limited
  // to the middle column or kept off it as mode says; all others repeat the stored value.
  task automatic send_frame(input int w, input int h, input chg_mode_t mode, input int pct,
                            input int lo, input int hi);
    int               a;
    bit               hit;
    logic [PIX_W-1:0] old_px;
    logic [PIX_W-1:0] mask;
    while (at_col != 0 || at_row != 0) put_pixel($urandom, FW_W'(2), FH_W'(2));
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        a      = r * MAX_WIDTH + c;
        old_px = shadow.exists(a) ? shadow[a] : $urandom;
        case (mode)
          CHG_MID_ONLY: hit = (c == w / 2);
          CHG_SKIP_MID: hit = (c != w / 2);
          default:      hit = 1'b1;
        endcase
        hit  = hit && r >= lo && r <= hi && $urandom_range(0, 99) < pct;
        mask = $urandom;
        if (mask == '0) mask = 32'h1;
        put_pixel(hit ? old_px ^ mask : old_px, FW_W'(w), FH_W'(h));
      end
    end
  endtask

  // result side: ready low in random bursts
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int               wf;
    int               hf;
    int               lo;
    int               hi;
    int               pct;
    int               n;
    int               start_px;
    int               start_fr;
    chg_mode_t        mode;
    logic [FW_W-1:0]  nw;
    logic [FH_W-1:0]  nh;
    rst_n               <= 1'b0;
    pix_ch.valid        <= 1'b0;
    pix_ch.pixel        <= '0;
    pix_ch.frame_width  <= '0;
    pix_ch.frame_height <= '0;
    src_idle_pct   = 10;
    sink_stall_pct = 30;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // no previous frame, then identical, off-middle only, one middle row, everything
    send_frame(4, 3, CHG_ANY, 100, 0, 2);
    send_frame(4, 3, CHG_ANY, 0, 0, 2);
    send_frame(4, 3, CHG_SKIP_MID, 100, 0, 2);
    send_frame(4, 3, CHG_MID_ONLY, 100, 1, 1);
    send_frame(4, 3, CHG_ANY, 100, 0, 2);
    // pixel extremes; sizes below range saturate to 2x2 and still compare
    repeat (4) put_pixel('0, FW_W'(2), FH_W'(2));
    repeat (4) put_pixel('1, FW_W'(0), FH_W'(1));
    repeat (4) put_pixel('1, FW_W'(1), FH_W'(0));
    // sizes above range, and a size change within a frame
    put_pixel($urandom, '1, '1);
    put_pixel($urandom, FW_W'(4097), FH_W'(2049));

    start_px = pixels_sent;
    start_fr = frames_closed;
    wf = 4;
    hf = 3;
    while (pixels_sent - start_px < 670 || frames_closed - start_fr < 30) begin
      quiet = (pixels_sent - start_px >= 560);
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 10;
        default: src_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 20;
        default: sink_stall_pct = 60;
      endcase
      if ($urandom_range(0, 9) < 2) begin
        // noise: arbitrary sizes, frames broken off in mid-row
        n = $urandom_range(1, 6);
        repeat (n) begin
          nw = $urandom_range(0, 1) ? FW_W'($urandom_range(0, 8191)) :
                                      FW_W'($urandom_range(0, 9));
          nh = $urandom_range(0, 1) ? FH_W'($urandom_range(0, 4095)) :
                                      FH_W'($urandom_range(0, 6));
          put_pixel($urandom, nw, nh);
        end
      end else begin
        // mostly repeat the size so frames compare
        if ($urandom_range(0, 99) >= 65) begin
          wf = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 6);
          hf = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : $urandom_range(2, 4);
        end
        mode = chg_mode_t'($urandom_range(0, 2));
        lo   = $urandom_range(0, hf - 1);
        hi   = $urandom_range(lo, hf - 1);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 5;
          2:       pct = 30;
          default: pct = 100;
        endcase
        send_frame(wf, hf, mode, pct, lo, hi);
      end
    end
    pix_ch.valid <= 1'b0;

    n = 0;
    while (rects_pending != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && rects_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fdrd_pkg.sv
rtl/fdrd_if.sv
rtl/fdrd_scan.sv
rtl/fdrd_frame_mem.sv
rtl/fdrd_track.sv
rtl/frame_dirty_row_detector.sv
tb/fdrd_checker.sv
tb/tb_frame_dirty_row_detector.sv
